### sv/hsvq_pkg.sv
// Shared types, constants and arithmetic helpers for the HSV to RGB grid quantizer.
// No dependencies; imported by hsvq_step and hsv_to_rgb_grid_quantizer.
`timescale 1ns / 1ps

package hsvq_pkg;

  localparam int unsigned HueW       = 15;
  localparam int unsigned ChanW      = 8;
  localparam int unsigned StepW      = 6;
  localparam int unsigned FracW      = 12;
  localparam int unsigned CxW        = 20;

  localparam logic [HueW-1:0]  HueMax       = 15'd23039;
  localparam logic [FracW-1:0] SectorUnits  = 12'd3840;
  localparam logic [CxW-1:0]   HalfSector   = 20'd1920;
  localparam logic [15:0]      Recip15      = 16'd34953;  // ceil(2^19 / 15)
  localparam logic [StepW-1:0] StepFieldMax = 6'd63;

  typedef enum logic [2:0] {
    SectorRedYellow    = 3'd0,
    SectorYellowGreen  = 3'd1,
    SectorGreenCyan    = 3'd2,
    SectorCyanBlue     = 3'd3,
    SectorBlueMagenta  = 3'd4,
    SectorMagentaRed   = 3'd5
  } sector_e;

  typedef struct packed {
    logic mul;
    logic step;
  } step_ld_t;

  // floor(n / 255), valid for n < 65535
  function automatic logic [8:0] div255(input logic [16:0] n);
    logic [16:0] t;
    t = n + 17'd1 + {8'd0, n[16:8]};
    return t[16:8];
  endfunction

  // floor(n / 3840) = floor(floor(n / 256) / 15), n < 2^20
  function automatic logic [8:0] div3840(input logic [CxW-1:0] n);
    logic [27:0] p;
    p = {4'd0, n[CxW-1:8]} * {12'd0, Recip15};
    return p[27:19];
  endfunction

endpackage

### sv/hsvq_step.sv
// Two-stage grid index unit for one color channel: multiply, then scaled round and clamp.
// Depends on hsvq_pkg; instantiated by hsv_to_rgb_grid_quantizer.
`timescale 1ns / 1ps

module hsvq_step
  import hsvq_pkg::*;
#(
  parameter int unsigned GRID_STEPS = 33
) (
  input  logic             clk_i,
  input  step_ld_t         ld_i,
  input  logic [ChanW-1:0] ch_i,
  output logic [ChanW-1:0] ch_o,
  output logic [StepW-1:0] step_o
);

  localparam logic [7:0] GridMax = 8'(GRID_STEPS - 1);

  logic [ChanW-1:0] ch_mul_q;
  logic [15:0]      prod_q, prod_d;
  logic [ChanW-1:0] ch_out_q;
  logic [StepW-1:0] step_q, step_d;
  logic [8:0]       quot;

  assign prod_d = {8'd0, ch_i} * {8'd0, GridMax};

  always_ff @(posedge clk_i) begin
    if (ld_i.mul) begin
      ch_mul_q <= ch_i;
      prod_q   <= prod_d;
    end
  end

  // (2*ch*(G-1) + 255) / 510 == (ch*(G-1) + 127) / 255
  always_comb begin
    quot = div255({1'b0, prod_q} + 17'd127);
    if (quot > {3'd0, StepFieldMax}) begin
      step_d = StepFieldMax;
    end else begin
      step_d = quot[StepW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.step) begin
      ch_out_q <= ch_mul_q;
      step_q   <= step_d;
    end
  end

  assign ch_o   = ch_out_q;
  assign step_o = step_q;

endmodule

### sv/hsv_to_rgb_grid_quantizer.sv
// Top level: HSV pixel to RGB plus per-channel grid index, six-stage pipeline.
// Depends on hsvq_pkg and hsvq_step.
`timescale 1ns / 1ps

// Usage:
//   Input stream s_axis: one HSV pixel per beat (hue in 1/64 degree, saturation,
//   brightness). Output stream m_axis: one beat per pixel with red, green, blue
//   and the nearest index of each on a grid of GRID_STEPS points over 0..255.
//   Throughput is one pixel per cycle while m_axis_tready_i is high; each stage
//   holds one pixel with its own valid bit, and a stage reloads whenever it is
//   empty or its successor moves. The hue sector split with the V*S product, the
//   chroma division, the C*frac product, the secondary term with channel
//   placement, the grid multiply and the grid rounding each take one stage.
//   When the receiver holds m_axis_tready_i low, the output beat is held and
//   upstream bubbles collapse; s_axis_tready_o drops only once all six stages
//   hold pixels. Nothing is dropped or repeated.
//   Reset clears all valid bits; the block is ready on the first cycle after
//   reset. Hue above 23039 is treated as 23039; a step above 63 reads 63.
module hsv_to_rgb_grid_quantizer
  import hsvq_pkg::*;
#(
  parameter int unsigned GRID_STEPS = 33
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // hue[14:0], saturation[22:15], brightness[30:23]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o    // red[7:0], green[15:8], blue[23:16],
                                        // red_step[29:24], green_step[35:30],
                                        // blue_step[41:36]
);

  localparam int unsigned NumStages = 6;

  logic [NumStages-1:0] v_q, v_d;
  logic [NumStages-1:0] ld;

  logic [HueW-1:0]  hue_in;
  logic [ChanW-1:0] sat_in, val_in;

  assign hue_in = s_axis_tdata_i[14:0];
  assign sat_in = s_axis_tdata_i[22:15];
  assign val_in = s_axis_tdata_i[30:23];

  // stage load enables, bubbles collapse
  always_comb begin
    ld[NumStages-1] = !v_q[NumStages-1] || m_axis_tready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      ld[k] = !v_q[k] || ld[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < NumStages; k++) begin
      if (ld[k]) begin
        v_d[k] = (k == 0) ? s_axis_tvalid_i : v_q[(k == 0) ? 0 : k - 1];
      end else begin
        v_d[k] = v_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign s_axis_tready_o = ld[0];

  // stage 1: sector split, V*S
  logic [HueW-1:0]  hue_c;
  sector_e          sec_d;
  logic [HueW-1:0]  base_d;
  sector_e          sec1_q;
  logic [FracW-1:0] frac1_q;
  logic [15:0]      vs1_q;
  logic [ChanW-1:0] val1_q;

  always_comb begin
    hue_c = (hue_in > HueMax) ? HueMax : hue_in;
    priority if (hue_c >= 15'd19200) begin
      sec_d  = SectorMagentaRed;
      base_d = 15'd19200;
    end else if (hue_c >= 15'd15360) begin
      sec_d  = SectorBlueMagenta;
      base_d = 15'd15360;
    end else if (hue_c >= 15'd11520) begin
      sec_d  = SectorCyanBlue;
      base_d = 15'd11520;
    end else if (hue_c >= 15'd7680) begin
      sec_d  = SectorGreenCyan;
      base_d = 15'd7680;
    end else if (hue_c >= 15'd3840) begin
      sec_d  = SectorYellowGreen;
      base_d = 15'd3840;
    end else begin
      sec_d  = SectorRedYellow;
      base_d = 15'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      sec1_q  <= sec_d;
      frac1_q <= FracW'(hue_c - base_d);
      vs1_q   <= {8'd0, val_in} * {8'd0, sat_in};
      val1_q  <= val_in;
    end
  end

  // stage 2: chroma, mirrored fraction on odd sectors
  sector_e          sec2_q;
  logic [ChanW-1:0] c2_q;
  logic [FracW-1:0] fsel2_q;
  logic [ChanW-1:0] val2_q;
  logic [8:0]       c_full;

  assign c_full = div255({1'b0, vs1_q} + 17'd127);

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      sec2_q  <= sec1_q;
      c2_q    <= c_full[ChanW-1:0];
      fsel2_q <= sec1_q[0] ? (SectorUnits - frac1_q) : frac1_q;
      val2_q  <= val1_q;
    end
  end

  // stage 3: C * frac
  sector_e          sec3_q;
  logic [ChanW-1:0] c3_q;
  logic [ChanW-1:0] val3_q;
  logic [CxW-1:0]   cx3_q;

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      sec3_q <= sec2_q;
      c3_q   <= c2_q;
      val3_q <= val2_q;
      cx3_q  <= {12'd0, c2_q} * {8'd0, fsel2_q};
    end
  end

  // stage 4: secondary term, channel placement, offset
  logic [8:0]       x_full;
  logic [ChanW-1:0] x4, m4;
  logic [ChanW-1:0] r_d, g_d, b_d;
  logic [ChanW-1:0] r4_q, g4_q, b4_q, val4_q, m4_q;

  always_comb begin
    x_full = div3840(cx3_q + HalfSector);
    x4     = x_full[ChanW-1:0];
    m4     = val3_q - c3_q;
    unique case (sec3_q)
      SectorRedYellow: begin
        r_d = c3_q; g_d = x4; b_d = '0;
      end
      SectorYellowGreen: begin
        r_d = x4; g_d = c3_q; b_d = '0;
      end
      SectorGreenCyan: begin
        r_d = '0; g_d = c3_q; b_d = x4;
      end
      SectorCyanBlue: begin
        r_d = '0; g_d = x4; b_d = c3_q;
      end
      SectorBlueMagenta: begin
        r_d = x4; g_d = '0; b_d = c3_q;
      end
      default: begin
        r_d = c3_q; g_d = '0; b_d = x4;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      r4_q   <= r_d + m4;
      g4_q   <= g_d + m4;
      b4_q   <= b_d + m4;
      val4_q <= val3_q;
      m4_q   <= m4;
    end
  end

  // stages 5 and 6: grid index per channel
  step_ld_t         step_ld;
  logic [ChanW-1:0] red, green, blue;
  logic [StepW-1:0] red_step, green_step, blue_step;

  assign step_ld = '{mul: ld[4], step: ld[5]};

  hsvq_step #(.GRID_STEPS(GRID_STEPS)) u_step_red (
    .clk_i  (clk_i),
    .ld_i   (step_ld),
    .ch_i   (r4_q),
    .ch_o   (red),
    .step_o (red_step)
  );

  hsvq_step #(.GRID_STEPS(GRID_STEPS)) u_step_green (
    .clk_i  (clk_i),
    .ld_i   (step_ld),
    .ch_i   (g4_q),
    .ch_o   (green),
    .step_o (green_step)
  );

  hsvq_step #(.GRID_STEPS(GRID_STEPS)) u_step_blue (
    .clk_i  (clk_i),
    .ld_i   (step_ld),
    .ch_i   (b4_q),
    .ch_o   (blue),
    .step_o (blue_step)
  );

  assign m_axis_tvalid_o = v_q[NumStages-1];
  assign m_axis_tdata_o  = {6'd0, blue_step, green_step, red_step, blue, green, red};

  // largest channel is V
  a_max_is_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] |-> (r4_q == val4_q || g4_q == val4_q || b4_q == val4_q))
    else $error("no channel equals brightness");

  // smallest channel is V - C
  a_min_is_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] |-> (r4_q == m4_q || g4_q == m4_q || b4_q == m4_q))
    else $error("no channel equals offset");

  // input stalls only with a full pipe and a stalled receiver
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (&v_q && !m_axis_tready_i))
    else $error("input stalled with room in pipe");

  // grid index is monotonic in channel value
  a_step_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && red >= green) |-> (red_step >= green_step))
    else $error("grid index not monotonic");

endmodule

### tb/hsv_to_rgb_grid_quantizer_tb.sv
// Self-checking testbench for hsv_to_rgb_grid_quantizer: directed and random HSV beats,
// predicted RGB and grid steps compared beat by beat. Depends on hsvq_pkg and the RTL.
`timescale 1ns / 1ps

module hsv_to_rgb_grid_quantizer_tb;
  import hsvq_pkg::*;

  localparam int unsigned GridSteps  = 33;
  localparam int unsigned RandItems  = 850;
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned HoldCycle  = 400;
  localparam int unsigned HoldLen    = 80;
  localparam int unsigned BurstStart = 700;
  localparam int unsigned BurstEnd   = 1000;

  typedef struct packed {
    logic [StepW-1:0] blue_step;
    logic [StepW-1:0] green_step;
    logic [StepW-1:0] red_step;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } rgb_beat_t;

  typedef struct {
    logic [31:0] beat;
    bit          drain_first;
  } pixel_req_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;   // hue[14:0], saturation[22:15], brightness[30:23]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [47:0] m_axis_tdata_o;   // red[7:0], green[15:8], blue[23:16],
                                 // red_step[29:24], green_step[35:30], blue_step[41:36]

  pixel_req_t  pixel_q[$];
  rgb_beat_t   rgb_expect_q[$];
  int unsigned cyc;
  int unsigned in_flight;
  int unsigned quiet_cycles;
  int unsigned hold_cnt;
  int unsigned mismatches;

  hsv_to_rgb_grid_quantizer #(
    .GRID_STEPS(GridSteps)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  function automatic logic [31:0] pack_hsv(input int unsigned h, input int unsigned s,
                                           input int unsigned v);
    logic [31:0] b;
    b = '0;
    b[14:0]  = h[14:0];
    b[22:15] = s[7:0];
    b[30:23] = v[7:0];
    return b;
  endfunction

  function automatic int unsigned grid_step(input int unsigned ch);
    int unsigned q;
    q = (2 * ch * (GridSteps - 1) + 255) / 510;
    return (q > StepFieldMax) ? StepFieldMax : q;
  endfunction

  function automatic rgb_beat_t predict_rgb(input logic [31:0] beat);
    int unsigned hue, sat, val, frac, c, x, m, r, g, b;
    sector_e     sec;
    rgb_beat_t   res;
    hue = 32'(beat[14:0]);
    sat = 32'(beat[22:15]);
    val = 32'(beat[30:23]);
    if (hue > HueMax) hue = 32'(HueMax);
    sec  = sector_e'(hue / SectorUnits);
    frac = hue % SectorUnits;
    c = (val * sat + 127) / 255;
    if (sec[0] == 1'b0) x = (2 * c * frac + SectorUnits) / (2 * SectorUnits);
    else x = (2 * c * (SectorUnits - frac) + SectorUnits) / (2 * SectorUnits);
    m = val - c;
    case (sec)
      SectorRedYellow: begin
        r = c; g = x; b = 0;
      end
      SectorYellowGreen: begin
        r = x; g = c; b = 0;
      end
      SectorGreenCyan: begin
        r = 0; g = c; b = x;
      end
      SectorCyanBlue: begin
        r = 0; g = x; b = c;
      end
      SectorBlueMagenta: begin
        r = x; g = 0; b = c;
      end
      default: begin
        r = c; g = 0; b = x;
      end
    endcase
    r += m;
    g += m;
    b += m;
    res.red        = r[7:0];
    res.green      = g[7:0];
    res.blue       = b[7:0];
    res.red_step   = StepW'(grid_step(r));
    res.green_step = StepW'(grid_step(g));
    res.blue_step  = StepW'(grid_step(b));
    return res;
  endfunction

  function automatic bit idle_now(input int unsigned c);
    if (c >= BurstStart && c < BurstEnd) return 1'b0;
    return $urandom_range(0, 99) < 22;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyc <= 0;
    end else begin
      cyc <= cyc + 1;
    end
  end

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    bit         hs;
    pixel_req_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
    end else begin
      hs = s_axis_tvalid_i && s_axis_tready_o;
      if (!s_axis_tvalid_i || hs) begin
        if (pixel_q.size() == 0) begin
          s_axis_tvalid_i <= 1'b0;
        end else if (pixel_q[0].drain_first && (in_flight != 0 || hs)) begin
          s_axis_tvalid_i <= 1'b0;
        end else if (idle_now(cyc)) begin
          s_axis_tvalid_i <= 1'b0;
        end else begin
          nxt = pixel_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= nxt.beat;
        end
      end
    end
  end

  // receiver, with one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      hold_cnt        <= 0;
    end else if (cyc == HoldCycle) begin
      m_axis_tready_i <= 1'b0;
      hold_cnt        <= HoldLen;
    end else if (hold_cnt > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_cnt        <= hold_cnt - 1;
    end else begin
      m_axis_tready_i <= !idle_now(cyc);
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i or negedge rst_ni) begin
    bit        in_hs, out_hs;
    rgb_beat_t act, exp_rgb;
    if (!rst_ni) begin
      in_flight    <= 0;
      quiet_cycles <= 0;
      mismatches   <= 0;
    end else begin
      in_hs  = s_axis_tvalid_i && s_axis_tready_o;
      out_hs = m_axis_tvalid_o && m_axis_tready_i;
      if (in_hs) rgb_expect_q.insert(rgb_expect_q.size(), predict_rgb(s_axis_tdata_i));
      if (out_hs) begin
        act = rgb_beat_t'(m_axis_tdata_o[41:0]);
        if (rgb_expect_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected output beat: %h", m_axis_tdata_o);
          mismatches <= mismatches + 1;
        end else begin
          exp_rgb = rgb_expect_q.pop_front();
          if (act.red != exp_rgb.red || act.green != exp_rgb.green ||
              act.blue != exp_rgb.blue || act.red_step != exp_rgb.red_step ||
              act.green_step != exp_rgb.green_step || act.blue_step != exp_rgb.blue_step) begin
            if (mismatches < 10)
              $display("beat mismatch: exp %0d %0d %0d / %0d %0d %0d, got %0d %0d %0d / %0d %0d %0d",
                       exp_rgb.red, exp_rgb.green, exp_rgb.blue, exp_rgb.red_step,
                       exp_rgb.green_step, exp_rgb.blue_step, act.red, act.green, act.blue,
                       act.red_step, act.green_step, act.blue_step);
            mismatches <= mismatches + 1;
          end
        end
      end
      in_flight <= in_flight + in_hs - out_hs;
      if (in_hs || out_hs) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("hsv_to_rgb_grid_quantizer: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned h, s, v, k, sel;
    pixel_req_t  req;
    rst_ni = 1'b0;

    // sector edges at full color
    for (k = 0; k < 6; k++) begin
      req.beat = pack_hsv(k * 3840, 255, 255);
      req.drain_first = 1'b0;
      pixel_q.insert(pixel_q.size(), req);
      req.beat = pack_hsv(k * 3840 + 3839, 255, 255);
      pixel_q.insert(pixel_q.size(), req);
    end
    // mid-sector, hue above range, gray, black, near-black and half saturation
    req.beat = pack_hsv(1920, 255, 128);
    pixel_q.insert(pixel_q.size(), req);
    req.beat = pack_hsv(23040, 255, 255);
    pixel_q.insert(pixel_q.size(), req);
    req.beat = pack_hsv(32767, 255, 255);
    pixel_q.insert(pixel_q.size(), req);
    req.beat = pack_hsv(32767, 200, 100);
    pixel_q.insert(pixel_q.size(), req);
    req.beat = pack_hsv(9000, 0, 200);
    pixel_q.insert(pixel_q.size(), req);
    req.beat = pack_hsv(17000, 255, 0);
    pixel_q.insert(pixel_q.size(), req);
    req.beat = pack_hsv(0, 0, 0);
    pixel_q.insert(pixel_q.size(), req);
    req.beat = pack_hsv(5000, 0, 255);
    pixel_q.insert(pixel_q.size(), req);
    req.beat = pack_hsv(12345, 1, 1);
    pixel_q.insert(pixel_q.size(), req);
    req.beat = pack_hsv(20000, 128, 255);
    pixel_q.insert(pixel_q.size(), req);

    for (k = 0; k < RandItems; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 80) h = $urandom_range(0, 23039);
      else if (sel < 90) h = $urandom_range(0, 5) * 3840 + $urandom_range(0, 2) + 3839;
      else h = $urandom_range(23040, 32767);
      if (h > 32767) h = 32767;
      sel = $urandom_range(0, 9);
      s = (sel == 0) ? 0 : (sel == 1) ? 255 : $urandom_range(0, 255);
      sel = $urandom_range(0, 9);
      v = (sel == 0) ? 0 : (sel == 1) ? 255 : $urandom_range(0, 255);
      req.beat = pack_hsv(h, s, v);
      req.drain_first = (k == 0) || (k == RandItems / 2);
      pixel_q.insert(pixel_q.size(), req);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pixel_q.size() != 0 || s_axis_tvalid_i || in_flight != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatches == 0 && rgb_expect_q.size() == 0) begin
      $display("hsv_to_rgb_grid_quantizer: match");
    end else begin
      $display("hsv_to_rgb_grid_quantizer: mismatch");
    end
    $finish;
  end

endmodule
